// ----- rtl/core/rirt_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rirt_pkg : shared types and constants of the request id remap table
// Slot count, item and result structs, kind codes, register codes and the
// lowest-set-bit search used for slot allocation and fetch.
// ============================================================================
package rirt_pkg;

    localparam int SLOTS   = 64;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = SLOT_W + 1;
    localparam int GRP     = 8;
    localparam int NGRP    = (SLOTS + GRP - 1) / GRP;
    localparam int PAD_W   = NGRP * GRP;

    localparam logic [15:0] TIMEOUT_START_RST = 16'd600;
    localparam logic [15:0] TIMEOUT_STEP_RST  = 16'd100;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_FINISH = 2'd1,
        KIND_FETCH  = 2'd2,
        KIND_TICK   = 2'd3
    } t_kind;

    typedef enum logic {
        CFG_TIMEOUT_START = 1'b0,
        CFG_TIMEOUT_STEP  = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TICK
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] client_id;
        logic [5:0]  slot;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [5:0]  slot_out;
        logic [15:0] client_id_out;
    } t_rsp;

    typedef struct packed {
        logic              id_we;
        logic              rem_we;
        logic [SLOT_W-1:0] addr;
        logic [15:0]       id;
        logic [15:0]       rem;
    } t_store_wr;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
    } t_hit;

    // Lowest set bit: pick the lowest non-empty group of eight, then the
    // lowest bit inside it.
    function automatic t_hit find_lowest(input logic [SLOTS-1:0] v);
        logic [PAD_W-1:0] pv;
        logic [NGRP-1:0]  any;
        logic [GRP-1:0]   bits;
        int               g;
        int               b;
        t_hit             res;
        pv  = PAD_W'(v);
        g   = 0;
        b   = 0;
        for (int k = 0; k < NGRP; k++) begin
            any[k] = |pv[k*GRP +: GRP];
        end
        for (int k = NGRP - 1; k >= 0; k--) begin
            if (any[k]) begin
                g = k;
            end
        end
        bits = pv[g*GRP +: GRP];
        for (int k = GRP - 1; k >= 0; k--) begin
            if (bits[k]) begin
                b = k;
            end
        end
        res.found = |any;
        res.idx   = SLOT_W'(g * GRP + b);
        return res;
    endfunction

endpackage

// ----- rtl/core/rirt_store.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rirt_store : per-slot storage
// Client id and remaining timeout memories, one write and one shared read
// address, read data registered.
// ============================================================================
module rirt_store (
    input  logic                       i_clk,
    input  logic [rirt_pkg::SLOT_W-1:0] i_rd_addr,
    input  rirt_pkg::t_store_wr        i_wr,
    output logic [15:0]                o_rd_id,
    output logic [15:0]                o_rd_rem
);
    import rirt_pkg::*;

    logic [15:0] r_id_mem  [SLOTS];
    logic [15:0] r_rem_mem [SLOTS];

    always_ff @(posedge i_clk) begin
        if (i_wr.id_we) begin
            r_id_mem[i_wr.addr] <= i_wr.id;
        end
        if (i_wr.rem_we) begin
            r_rem_mem[i_wr.addr] <= i_wr.rem;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rd_id  <= r_id_mem[i_rd_addr];
        o_rd_rem <= r_rem_mem[i_rd_addr];
    end

endmodule

// ----- rtl/core/request_id_remap_table.sv -----
`timescale 1ns / 1ps
// ============================================================================
// request_id_remap_table : outstanding request table with id remapping
// Maps client transaction ids to local slots, with allocation, release,
// fetch of unserved entries and a timeout sweep.
// ============================================================================
// Usage
//   Command channel: drive i_item and raise start; the item is taken on an
//   edge where start is high and busy is low. Kinds: add, finish, fetch,
//   tick.
//   Result channel: o_done pulses for one cycle with o_result; there is no
//   back-pressure, the receiver must take it in that cycle.
//   Config channel: i_cfg_valid / o_cfg_ready (always ready), index 0 is
//   timeout_start, index 1 is timeout_step. Write only while idle.
// Timing
//   Add, finish, fetch: accept (item latched), then execute, then the
//   result is registered; the next item may be taken while it is out.
//   Tick: walks every slot through the timeout memory, one slot a cycle,
//   read-modify-write pipelined; busy for the whole sweep, result on the
//   cycle after the last slot, when the next item may be taken.
//   The slot search is a lowest-bit search over the busy/served flags,
//   done in the accept cycle; it addresses the id memory for fetch.
// Reset
//   Synchronous, active low: all slots free and unserved, registers back
//   to 600 / 100. No clearing pass; id and timeout memories are only used
//   for slots written since.
// ============================================================================
module request_id_remap_table (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  rirt_pkg::t_req i_item,
    output logic           o_done,
    output rirt_pkg::t_rsp o_result,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic           i_cfg_index,
    input  logic [15:0]    i_cfg_data
);
    import rirt_pkg::*;

    // control
    t_state            r_state;
    t_state            n_state;
    logic              accept;
    logic [CNT_W-1:0]  r_cnt;

    // latched item and search result
    t_kind             r_kind;
    logic [15:0]       r_cid;
    logic [5:0]        r_slot;
    logic              r_hit;
    logic [SLOT_W-1:0] r_idx;

    // flags, cleared at reset
    logic [SLOTS-1:0]  r_busy_flags;
    logic [SLOTS-1:0]  r_served_flags;

    // configuration
    logic [15:0]       r_timeout_start;
    logic [15:0]       r_timeout_step;

    // result register
    logic              r_done;
    t_rsp              r_rsp;

    // search and memory
    logic [SLOTS-1:0]  search_vec;
    t_hit              search;
    logic [SLOT_W-1:0] rd_addr;
    t_store_wr         wr;
    logic [15:0]       rd_id;
    logic [15:0]       rd_rem;

    // tick pipeline: entry whose timeout is in rd_rem this cycle
    logic [SLOT_W-1:0] tick_entry;
    logic              tick_last;
    logic [15:0]       tick_rem;

    // finish target check
    logic              fin_hit;

    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_result    = r_rsp;

    assign tick_entry = SLOT_W'(r_cnt - CNT_W'(1));
    assign tick_last  = (r_cnt == CNT_W'(SLOTS));
    assign tick_rem   = (rd_rem > r_timeout_step) ? (rd_rem - r_timeout_step) : 16'd0;
    assign fin_hit    = (int'(r_slot) < SLOTS) && r_busy_flags[SLOT_W'(r_slot)];

    // add looks for a free slot, fetch for a busy unserved one
    assign search_vec = (i_item.kind == KIND_ADD) ? ~r_busy_flags
                                                  : (r_busy_flags & ~r_served_flags);
    assign search     = find_lowest(search_vec);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_item.kind == KIND_TICK) ? ST_TICK : ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            ST_TICK: begin
                if (tick_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ---------------- state outputs ----------------
    always_comb begin
        busy    = 1'b1;
        rd_addr = r_cnt[SLOT_W-1:0];
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                case (i_item.kind)
                    KIND_FINISH: rd_addr = SLOT_W'(i_item.slot);
                    KIND_FETCH:  rd_addr = search.idx;
                    default:     rd_addr = '0;
                endcase
            end
            ST_EXEC: begin
                rd_addr = r_idx;
            end
            ST_TICK: begin
                rd_addr = r_cnt[SLOT_W-1:0];
            end
            default: begin
                rd_addr = '0;
            end
        endcase
    end

    // ---------------- memory write ----------------
    always_comb begin
        wr        = '0;
        wr.id     = r_cid;
        wr.rem    = r_timeout_start;
        wr.addr   = r_idx;
        if (r_state == ST_EXEC && r_kind == KIND_ADD && r_hit) begin
            wr.id_we  = 1'b1;
            wr.rem_we = 1'b1;
        end else if (r_state == ST_TICK && r_busy_flags[tick_entry]) begin
            wr.rem_we = 1'b1;
            wr.addr   = tick_entry;
            wr.rem    = tick_rem;
        end
    end

    rirt_store u_store (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .i_wr      (wr),
        .o_rd_id   (rd_id),
        .o_rd_rem  (rd_rem)
    );

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_cnt <= CNT_W'(1);
            end else if (r_state == ST_TICK) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    // item latch, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_item.kind;
            r_cid  <= i_item.client_id;
            r_slot <= i_item.slot;
            r_hit  <= search.found;
            r_idx  <= search.idx;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_start <= TIMEOUT_START_RST;
            r_timeout_step  <= TIMEOUT_STEP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TIMEOUT_START: r_timeout_start <= i_cfg_data;
                CFG_TIMEOUT_STEP:  r_timeout_step  <= i_cfg_data;
                default:           r_timeout_step  <= r_timeout_step;
            endcase
        end
    end

    // ---------------- slot flags ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_flags   <= '0;
            r_served_flags <= '0;
        end else if (r_state == ST_EXEC) begin
            case (r_kind)
                KIND_ADD: begin
                    if (r_hit) begin
                        r_busy_flags[r_idx]   <= 1'b1;
                        r_served_flags[r_idx] <= 1'b0;
                    end
                end
                KIND_FINISH: begin
                    if (fin_hit) begin
                        r_busy_flags[SLOT_W'(r_slot)] <= 1'b0;
                    end
                end
                KIND_FETCH: begin
                    if (r_hit) begin
                        r_served_flags[r_idx] <= 1'b1;
                    end
                end
                default: begin
                    r_busy_flags <= r_busy_flags;
                end
            endcase
        end else if (r_state == ST_TICK) begin
            // expire slots whose timeout ran out on this sweep
            if (r_busy_flags[tick_entry] && tick_rem == 16'd0) begin
                r_busy_flags[tick_entry] <= 1'b0;
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == ST_EXEC) || (r_state == ST_TICK && tick_last);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= '0;
        if (r_state == ST_EXEC) begin
            case (r_kind)
                KIND_ADD: begin
                    if (r_hit) begin
                        r_rsp.ok       <= 1'b1;
                        r_rsp.slot_out <= 6'(r_idx);
                    end
                end
                KIND_FINISH: begin
                    if (fin_hit) begin
                        r_rsp.ok            <= 1'b1;
                        r_rsp.client_id_out <= rd_id;
                    end
                end
                KIND_FETCH: begin
                    if (r_hit) begin
                        r_rsp.ok            <= 1'b1;
                        r_rsp.slot_out      <= 6'(r_idx);
                        r_rsp.client_id_out <= rd_id;
                    end
                end
                default: begin
                    r_rsp.ok <= 1'b1;
                end
            endcase
        end else if (r_state == ST_TICK && tick_last) begin
            r_rsp.ok <= 1'b1;
        end
    end

    // ---------------- assertions ----------------
    a_done_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) == ST_EXEC) || ($past(r_state) == ST_TICK))
        else $error("result without an execute or sweep end");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("busy not raised after accept");

    a_tick_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && r_kind == KIND_TICK |-> o_result.ok)
        else $error("tick result not ok");

    a_add_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && r_kind == KIND_ADD && o_result.ok |-> r_busy_flags[r_idx])
        else $error("granted slot not marked busy");

    a_fetch_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && r_kind == KIND_FETCH && o_result.ok |-> r_served_flags[r_idx])
        else $error("fetched slot not marked served");

endmodule
